FILE: rtl/core/pcn_pkg.sv
// Shared types and constants for the peak calibrated normalizer.
// Used by every module under rtl/core; depends on nothing else.
package pcn_pkg;

   localparam int CHANNELS_DEFAULT    = 12;
   localparam int SAMPLE_BITS_DEFAULT = 8;
   localparam int CMD_QUEUE_DEPTH     = 2;

   localparam int CHANNEL_BITS = 4;
   localparam int SAMPLE_WIDTH = 8;
   localparam int PEAK_BITS    = 8;
   localparam int NORM_BITS    = 11;
   localparam int NORM_SHIFT   = 7;
   localparam int THRESH_BITS  = 8;

   localparam logic [NORM_BITS-1:0]   NORM_MAX        = 11'd2047;
   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 8'd20;

   localparam logic [1:0] ACT_CALIBRATE = 2'd0;
   localparam logic [1:0] ACT_NORMALIZE = 2'd1;
   localparam logic [1:0] ACT_PRESET    = 2'd2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [1:0]              action;
      logic [CHANNEL_BITS-1:0] channel;
      logic [SAMPLE_WIDTH-1:0] sample;
   } pcn_req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] channel_out;
      logic [NORM_BITS-1:0]    normalized;
      logic [PEAK_BITS-1:0]    peak;
      logic                    updated;
   } pcn_rsp_type;

   typedef enum logic [2:0] {
      KIND_CALIBRATE,
      KIND_NORMALIZE,
      KIND_PRESET,
      KIND_HOLD,
      KIND_OUT_OF_RANGE
   } pcn_kind_type;

   typedef struct packed {
      pcn_kind_type            kind;
      logic [CHANNEL_BITS-1:0] channel;
      logic [SAMPLE_WIDTH-1:0] sample;
   } pcn_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } pcn_state_type;

endpackage

FILE: rtl/core/pcn_front.sv
// Front end: decodes the action, checks the channel range and masks the sample.
// Depends on pcn_pkg.
module pcn_front #(
   parameter int CHANNELS    = pcn_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = pcn_pkg::SAMPLE_BITS_DEFAULT
) (
   input  pcn_pkg::pcn_req_type req,
   output pcn_pkg::pcn_cmd_type cmd
);

   localparam int SBE = (SAMPLE_BITS < pcn_pkg::SAMPLE_WIDTH) ? SAMPLE_BITS
                                                               : pcn_pkg::SAMPLE_WIDTH;
   localparam logic [pcn_pkg::SAMPLE_WIDTH-1:0] SMP_MASK =
      pcn_pkg::SAMPLE_WIDTH'((16'd1 << SBE) - 16'd1);

   logic in_range;

   assign in_range = {1'b0, req.channel} < (pcn_pkg::CHANNEL_BITS + 1)'(CHANNELS);

   always_comb begin
      cmd.channel = req.channel;
      cmd.sample  = req.sample & SMP_MASK;
      if (!in_range) begin
         cmd.kind = pcn_pkg::KIND_OUT_OF_RANGE;
      end else begin
         unique case (req.action)
            pcn_pkg::ACT_CALIBRATE: cmd.kind = pcn_pkg::KIND_CALIBRATE;
            pcn_pkg::ACT_NORMALIZE: cmd.kind = pcn_pkg::KIND_NORMALIZE;
            pcn_pkg::ACT_PRESET:    cmd.kind = pcn_pkg::KIND_PRESET;
            default:                cmd.kind = pcn_pkg::KIND_HOLD;
         endcase
      end
   end

endmodule

FILE: rtl/core/pcn_cmd_queue.sv
// Short command queue between front end and back end.
// Depends on pcn_pkg for the command type.
module pcn_cmd_queue #(
   parameter int DEPTH = pcn_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcn_pkg::pcn_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output pcn_pkg::pcn_cmd_type head_cmd,
   output logic                 empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pcn_pkg::pcn_cmd_type entry_ff [DEPTH];
   pcn_pkg::pcn_cmd_type entry_in [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push_ok, pop_ok;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         entry_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/pcn_back.sv
// Back end: channel stores, restoring divider and result register.
// Depends on pcn_pkg.
module pcn_back #(
   parameter int CHANNELS = pcn_pkg::CHANNELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcn_pkg::pcn_cmd_type                  cmd,
   input  logic                                  cmd_valid,
   output logic                                  cmd_pop,
   input  logic [pcn_pkg::THRESH_BITS-1:0]       threshold,
   output pcn_pkg::pcn_rsp_type                  rsp,
   output logic                                  rsp_valid,
   input  logic                                  rsp_pop
);

   localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DW   = pcn_pkg::PEAK_BITS + pcn_pkg::NORM_BITS;
   localparam int CNTW = $clog2(pcn_pkg::NORM_BITS);
   localparam int NB   = pcn_pkg::NORM_BITS;

   pcn_pkg::pcn_state_type state_ff, state_in;
   logic [pcn_pkg::PEAK_BITS-1:0] peak_ff [CHANNELS];
   logic [pcn_pkg::PEAK_BITS-1:0] peak_in [CHANNELS];
   logic [NB-1:0]                 norm_ff [CHANNELS];
   logic [NB-1:0]                 norm_in [CHANNELS];
   logic [DW-1:0]   rem_ff, rem_in, div_ff, div_in;
   logic [NB-1:0]   quo_ff, quo_in, quo_next;
   logic [CNTW-1:0] count_ff, count_in;
   logic [IW-1:0]   idx_ff, idx_in, idx;
   logic [pcn_pkg::CHANNEL_BITS-1:0] chan_ff, chan_in;
   pcn_pkg::pcn_rsp_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   logic [pcn_pkg::PEAK_BITS-1:0] cur_peak;
   logic [NB-1:0]                 cur_norm;
   logic [DW-1:0]                 dividend;
   logic                          start, div_ok, sat, go_divide, fits;

   assign idx      = cmd.channel[IW-1:0];
   assign cur_peak = peak_ff[idx];
   assign cur_norm = norm_ff[idx];
   assign dividend = DW'(cmd.sample) << pcn_pkg::NORM_SHIFT;
   assign div_ok   = (cur_peak != '0) && (cur_peak >= threshold);
   assign sat      = dividend >= (DW'(cur_peak) << NB);
   assign start    = (state_ff == pcn_pkg::ST_IDLE) && cmd_valid
                     && (!out_valid_ff || rsp_pop);
   assign go_divide = start && (cmd.kind == pcn_pkg::KIND_NORMALIZE) && div_ok && !sat;
   assign fits     = rem_ff >= div_ff;
   assign quo_next = {quo_ff[NB-2:0], fits};

   assign cmd_pop   = start;
   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcn_pkg::ST_IDLE: begin
            if (go_divide) state_in = pcn_pkg::ST_DIVIDE;
         end
         pcn_pkg::ST_DIVIDE: begin
            if (count_ff == '0) state_in = pcn_pkg::ST_IDLE;
         end
         default: state_in = pcn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      peak_in      = peak_ff;
      norm_in      = norm_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      chan_in      = chan_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      unique case (state_ff)
         pcn_pkg::ST_IDLE: begin
            if (start) begin
               out_in.channel_out = cmd.channel;
               out_in.normalized  = cur_norm;
               out_in.peak        = cur_peak;
               out_in.updated     = 1'b0;
               out_valid_in       = 1'b1;
               case (cmd.kind)
                  pcn_pkg::KIND_CALIBRATE: begin
                     if (cmd.sample > cur_peak) begin
                        peak_in[idx] = cmd.sample;
                        out_in.peak  = cmd.sample;
                     end
                  end
                  pcn_pkg::KIND_PRESET: begin
                     peak_in[idx] = cmd.sample;
                     out_in.peak  = cmd.sample;
                  end
                  pcn_pkg::KIND_NORMALIZE: begin
                     if (div_ok && sat) begin
                        norm_in[idx]      = pcn_pkg::NORM_MAX;
                        out_in.normalized = pcn_pkg::NORM_MAX;
                        out_in.updated    = 1'b1;
                     end else if (div_ok) begin
                        out_valid_in = out_valid_ff && !rsp_pop;
                        rem_in       = dividend;
                        div_in       = DW'(cur_peak) << (NB - 1);
                        quo_in       = '0;
                        count_in     = CNTW'(NB - 1);
                        idx_in       = idx;
                        chan_in      = cmd.channel;
                     end
                  end
                  pcn_pkg::KIND_OUT_OF_RANGE: begin
                     out_in.normalized = '0;
                     out_in.peak       = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pcn_pkg::ST_DIVIDE: begin
            if (fits) rem_in = rem_ff - div_ff;
            div_in   = div_ff >> 1;
            quo_in   = quo_next;
            count_in = count_ff - CNTW'(1);
            if (count_ff == '0) begin
               norm_in[idx_ff]    = quo_next;
               out_in.channel_out = chan_ff;
               out_in.normalized  = quo_next;
               out_in.peak        = peak_ff[idx_ff];
               out_in.updated     = 1'b1;
               out_valid_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      chan_ff  <= chan_in;
      out_ff   <= out_in;
      if (reset) begin
         state_ff     <= pcn_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            peak_ff[i] <= '0;
            norm_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         peak_ff      <= peak_in;
         norm_ff      <= norm_in;
      end
   end

endmodule

FILE: rtl/core/peak_calibrated_normalizer_unit.sv
// Calibrate, preset, hold, out-of-range and non-dividing normalize items show a result in
// the output register in the cycle after acceptance; a dividing normalize first runs the
// 11-step restoring divider. The back end takes one item per cycle for simple actions while
// the output register is free or popped, and takes no new item while a division runs.
// Two commands queue ahead of the back end, one result waits in the output register.
// Synchronous active-high reset zeroes both channel stores and sets the threshold to 20.
module peak_calibrated_normalizer_unit #(
   parameter int CHANNELS    = pcn_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = pcn_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  pcn_pkg::pcn_req_type                req_payload,
   output logic                                full,
   output logic                                empty,
   input  logic                                pop,
   output pcn_pkg::pcn_rsp_type                rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pcn_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [pcn_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [pcn_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   logic [pcn_pkg::THRESH_BITS-1:0] thresh_ff, thresh_in;
   logic                            csr_write;
   pcn_pkg::pcn_cmd_type            front_cmd, head_cmd;
   logic                            q_empty, q_pop, rsp_valid;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write && paddr[2] == pcn_pkg::CSR_IDX_THRESHOLD) begin
         thresh_in = pwdata[pcn_pkg::THRESH_BITS-1:0];
      end
      prdata = '0;
      if (paddr[2] == pcn_pkg::CSR_IDX_THRESHOLD) begin
         prdata = pcn_pkg::CSR_DATA_BITS'(thresh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= pcn_pkg::THRESHOLD_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   pcn_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req (req_payload),
      .cmd (front_cmd)
   );

   pcn_cmd_queue #(
      .DEPTH (pcn_pkg::CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .full     (full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   pcn_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_valid (!q_empty),
      .cmd_pop   (q_pop),
      .threshold (thresh_ff),
      .rsp       (rsp_payload),
      .rsp_valid (rsp_valid),
      .rsp_pop   (pop)
   );

   assign empty = !rsp_valid;

endmodule
